// ===== rtl/hic_pkg.sv =====
// hic_pkg: shared types, constants and codes of the hash index compactor
// used by every file under rtl except hic_ram; depends on nothing else
package hic_pkg;

  // field widths fixed by the transaction formats
  localparam int IDX_W    = 24;
  localparam int KEY_W    = IDX_W + 1;
  localparam int RAW_W    = 32;
  localparam int LG_W     = 4;
  localparam int CFG_W    = IDX_W;
  localparam int CFG_IDX_W = 1;

  // default table size and limits on table_log2
  localparam int TABLE_LOG2_MAX_DEF = 12;
  localparam int LG_MIN             = 4;

  // multiplicative hash constant
  localparam logic [31:0] HASH_MUL = 32'd2654435761;

  // register reset values
  localparam logic [IDX_W-1:0] POS_COUNT_RST  = IDX_W'(1);
  localparam logic [LG_W-1:0]  TABLE_LOG2_RST = LG_W'(12);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POS_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOG2 = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_COUNT = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_index;
    logic                    start_new;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] compact_index;
    logic [IDX_W-1:0] source_index;
    logic             first_seen;
    logic [1:0]       status;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic clear_init;
    logic clear_wr;
    logic resolve;
    logic hash;
    logic read;
    logic check;
    logic emit;
  } hic_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic aborted;
    logic probe_done;
    logic out_free;
  } hic_sts_t;

endpackage

// ===== rtl/hic_ram.sv =====
// hic_ram: generic single-write, single-read ram with registered read data
// stand-alone, no package dependency
module hic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/hic_ctrl.sv =====
// hic_ctrl: sequencing state machine of the hash index compactor
// depends on hic_pkg for the command and status structs
module hic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_start_new,
  output logic              in_stall,
  input  hic_pkg::hic_sts_t sts,
  output hic_pkg::hic_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RESOLVE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   pend_r;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      S_IDLE: begin
        cmd.load_in    = accept;
        cmd.clear_init = accept && in_start_new;
      end
      S_RESOLVE: cmd.resolve = 1'b1;
      S_HASH:    cmd.hash    = 1'b1;
      S_READ:    cmd.read    = 1'b1;
      S_CHECK:   cmd.check   = 1'b1;
      S_EMIT:    cmd.emit    = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pend_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (sts.clear_last) begin
            state_r <= pend_r ? S_RESOLVE : S_IDLE;
            pend_r  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_start_new) begin
              state_r <= S_CLEAR;
              pend_r  <= 1'b1;
            end else begin
              state_r <= S_RESOLVE;
            end
          end
        end
        S_RESOLVE: state_r <= sts.aborted ? S_EMIT : S_HASH;
        S_HASH:    state_r <= S_READ;
        S_READ:    state_r <= S_CHECK;
        S_CHECK:   state_r <= sts.probe_done ? S_EMIT : S_READ;
        S_EMIT: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/hic_datapath.sv =====
// hic_datapath: registers, index resolution, hash, probe logic and output stage
// depends on hic_pkg and instantiates hic_ram for the slot table
module hic_datapath #(
  parameter int TABLE_LOG2_MAX = hic_pkg::TABLE_LOG2_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [hic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hic_pkg::CFG_W-1:0]     cfg_wdata,
  input  hic_pkg::in_t                  in_data,
  output hic_pkg::out_t                 out_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  hic_pkg::hic_cmd_t             cmd,
  output hic_pkg::hic_sts_t             sts
);

  localparam int AW    = TABLE_LOG2_MAX;
  localparam int DEPTH = 1 << AW;
  localparam int IW    = hic_pkg::IDX_W;
  localparam int KW    = hic_pkg::KEY_W;
  localparam int DW    = KW + IW;
  localparam int RW    = hic_pkg::RAW_W + 2;

  // configuration
  logic [IW-1:0]           pos_count_r;
  logic [hic_pkg::LG_W-1:0] table_log2_r;

  // control state
  logic [AW-1:0] clr_ptr_r;
  logic [IW-1:0] unique_r;
  logic          aborted_r;
  logic [1:0]    abort_code_r;
  logic          out_valid_r;

  // payload
  logic signed [hic_pkg::RAW_W-1:0] raw_r;
  logic [IW-1:0] source_r;
  logic [KW-1:0] key_r;
  logic [AW-1:0] slot_r;
  logic [AW:0]   probe_r;
  logic [IW-1:0] res_compact_r;
  logic          res_first_r;
  logic [1:0]    res_status_r;
  hic_pkg::out_t out_r;

  // combinational
  logic signed [RW-1:0] raw_ext, cnt_ext, sum_rel, dec_pos;
  logic [IW-1:0] source_res;
  logic [4:0]    lg_ext, lg_c;
  logic [AW-1:0] mask;
  logic [KW-1:0] key_w;
  logic [31:0]   prod;
  logic [KW-1:0] rd_key;
  logic [IW-1:0] rd_comp;
  logic          hit, empty, exhausted, cnt_hit, out_free;
  logic [AW:0]   probe_nxt;
  logic [IW-1:0] unique_nxt;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [DW-1:0] ram_wr_data, ram_rd_data;

  // index resolution
  always_comb begin
    raw_ext = RW'(raw_r);
    cnt_ext = signed'(RW'(pos_count_r));
    sum_rel = raw_ext + cnt_ext;
    dec_pos = raw_ext - RW'(1);
    if (raw_ext > RW'(0)) begin
      source_res = (raw_ext <= cnt_ext) ? dec_pos[IW-1:0] : '0;
    end else begin
      source_res = sum_rel[RW-1] ? '0 : sum_rel[IW-1:0];
    end
  end

  // table size clamp
  always_comb begin
    lg_ext = 5'(table_log2_r);
    if (lg_ext < 5'(hic_pkg::LG_MIN)) begin
      lg_c = 5'(hic_pkg::LG_MIN);
    end else if (lg_ext > 5'(TABLE_LOG2_MAX)) begin
      lg_c = 5'(TABLE_LOG2_MAX);
    end else begin
      lg_c = lg_ext;
    end
    mask = ~({AW{1'b1}} << lg_c);
  end

  assign key_w = KW'(source_r) + KW'(1);
  assign prod  = 32'(32'(key_w) * hic_pkg::HASH_MUL);

  // probe compare
  assign rd_key     = ram_rd_data[DW-1 -: KW];
  assign rd_comp    = ram_rd_data[IW-1:0];
  assign hit        = (rd_key == key_r);
  assign empty      = (rd_key == '0);
  assign probe_nxt  = probe_r + (AW+1)'(1);
  assign exhausted  = (probe_nxt > {1'b0, mask});
  assign unique_nxt = unique_r + IW'(1);
  assign cnt_hit    = (unique_nxt >= pos_count_r) || (unique_nxt == '0);
  assign out_free   = !out_valid_r || !out_stall;

  assign ram_wr_en   = cmd.clear_wr || (cmd.check && !hit && empty);
  assign ram_wr_addr = cmd.clear_wr ? clr_ptr_r : slot_r;
  assign ram_wr_data = cmd.clear_wr ? '0 : {key_r, unique_r};

  hic_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.read),
    .rd_addr (slot_r),
    .rd_data (ram_rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_count_r  <= hic_pkg::POS_COUNT_RST;
      table_log2_r <= hic_pkg::TABLE_LOG2_RST;
      clr_ptr_r    <= '0;
      unique_r     <= '0;
      aborted_r    <= 1'b0;
      abort_code_r <= hic_pkg::STATUS_OK;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          hic_pkg::CFG_POS_COUNT:  pos_count_r  <= cfg_wdata[IW-1:0];
          hic_pkg::CFG_TABLE_LOG2: table_log2_r <= cfg_wdata[hic_pkg::LG_W-1:0];
        endcase
      end
      if (cmd.clear_init) begin
        clr_ptr_r    <= '0;
        unique_r     <= '0;
        aborted_r    <= 1'b0;
        abort_code_r <= hic_pkg::STATUS_OK;
      end
      if (cmd.clear_wr) begin
        clr_ptr_r <= clr_ptr_r + AW'(1);
      end
      if (cmd.check) begin
        if (!hit && empty) begin
          unique_r <= unique_nxt;
          if (cnt_hit) begin
            aborted_r    <= 1'b1;
            abort_code_r <= hic_pkg::STATUS_COUNT;
          end
        end else if (!hit && exhausted) begin
          aborted_r    <= 1'b1;
          abort_code_r <= hic_pkg::STATUS_FULL;
        end
      end
      if (cmd.emit && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_r <= in_data.raw_index;
    end
    if (cmd.resolve) begin
      source_r      <= source_res;
      res_compact_r <= '0;
      res_first_r   <= 1'b0;
      res_status_r  <= abort_code_r;
    end
    if (cmd.hash) begin
      key_r   <= key_w;
      slot_r  <= prod[AW-1:0] & mask;
      probe_r <= '0;
    end
    if (cmd.check) begin
      if (hit) begin
        res_compact_r <= rd_comp;
        res_first_r   <= 1'b0;
        res_status_r  <= hic_pkg::STATUS_OK;
      end else if (empty) begin
        res_compact_r <= unique_r;
        res_first_r   <= 1'b1;
        res_status_r  <= cnt_hit ? hic_pkg::STATUS_COUNT : hic_pkg::STATUS_OK;
      end else if (exhausted) begin
        res_compact_r <= '0;
        res_first_r   <= 1'b0;
        res_status_r  <= hic_pkg::STATUS_FULL;
      end else begin
        slot_r  <= (slot_r + AW'(1)) & mask;
        probe_r <= probe_nxt;
      end
    end
    if (cmd.emit && out_free) begin
      out_r.compact_index <= res_compact_r;
      out_r.source_index  <= source_r;
      out_r.first_seen    <= res_first_r;
      out_r.status        <= res_status_r;
    end
  end

  assign sts.clear_last = (clr_ptr_r == {AW{1'b1}});
  assign sts.aborted    = aborted_r;
  assign sts.probe_done = hit || empty || exhausted;
  assign sts.out_free   = out_free;

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/hash_index_compactor.sv =====
// hash_index_compactor: top level, joins the controller and the datapath
// depends on hic_pkg, hic_ctrl, hic_datapath (and through it hic_ram)
//
// usage
//   input channel in_valid/in_stall/in_data carries one raw index and a
//   start_new flag; each input transaction yields exactly one output
//   transaction on out_valid/out_stall/out_data, in order
//   cfg_wr_en/cfg_index/cfg_wdata writes pos_count or table_log2; write only
//   while no transaction is in flight
// timing
//   one item at a time; the table is probed through a single ram read port,
//   each probed slot being read, then compared and possibly inserted into;
//   an item probes 1 .. 2^table_log2 slots, none while aborted
//   start_new adds a clearing sweep of all 2^TABLE_LOG2_MAX slots before the item
// reset
//   synchronous active-low reset; afterwards the slot table is swept to empty
//   entry by entry, all 2^TABLE_LOG2_MAX of them, with in_stall high, config regs go to defaults
// backpressure
//   the finished result sits in the output register while out_stall is high;
//   the next input transaction is taken meanwhile and waits in its final state
module hash_index_compactor #(
  parameter int TABLE_LOG2_MAX = hic_pkg::TABLE_LOG2_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [hic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hic_pkg::CFG_W-1:0]     cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hic_pkg::in_t                  in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output hic_pkg::out_t                 out_data
);

  hic_pkg::hic_cmd_t ctrl_cmd;
  hic_pkg::hic_sts_t dp_sts;

  // sequencing: clear sweep, resolve, hash, probe loop, emit
  hic_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_start_new (in_data.start_new),
    .in_stall     (in_stall),
    .sts          (dp_sts),
    .cmd          (ctrl_cmd)
  );

  // registers, slot table and output stage
  hic_datapath #(
    .TABLE_LOG2_MAX (TABLE_LOG2_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (ctrl_cmd),
    .sts       (dp_sts)
  );

`ifndef SYNTHESIS
  // a newly inserted source never reports a full table
  a_first_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.first_seen |-> out_data.status != hic_pkg::STATUS_FULL)
    else $error("first_seen result carries table-full status");

  // a full-table result always has compact index zero
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == hic_pkg::STATUS_FULL) |-> out_data.compact_index == '0)
    else $error("table-full result with nonzero compact index");

  // no input transaction is taken while the table is being cleared
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.clear_wr |-> in_stall)
    else $error("input not stalled during clearing sweep");

  // the clearing sweep ends right after its last entry
  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.clear_wr && dp_sts.clear_last |=> !ctrl_cmd.clear_wr)
    else $error("clearing sweep ran past the last entry");
`endif

endmodule
